[hdl/plc_pkg.sv]
// ----------------------------------------------------------------------------
// plc_pkg : shared types and constants for the curve lookup
// Status and operation codes, state type and default sizes.
// ----------------------------------------------------------------------------
package plc_pkg;

  localparam int MAX_KNOTS_DEF = 32;

  localparam int KNOT_COUNT_W = 6;
  localparam logic [KNOT_COUNT_W-1:0] KNOT_COUNT_RST = 6'd20;

  localparam int INDEX_W = 5;
  localparam int TERM_W  = 32;
  localparam int RATE_W  = 32;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 32;

  localparam int CNT_W     = 6;
  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 33;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_INTERP = 3'd0,
    ST_LOW    = 3'd1,
    ST_HIGH   = 3'd2,
    ST_NONE   = 3'd3,
    ST_WRITE  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_CLAMP,
    S_RATE0,
    S_RATE1,
    S_DT,
    S_DQ,
    S_DIFF,
    S_MAG,
    S_MUL,
    S_DIV,
    S_FIN,
    S_RESP
  } state_t;

endpackage

[hdl/piecewise_linear_curve_lookup_top.sv]
// ----------------------------------------------------------------------------
// piecewise_linear_curve_lookup_top : knot store and curve evaluation
// Knot writes fill the store; a query scans the knots, then clamps to an
// end knot or interpolates inside the bracketing segment with a shared adder
// (shift-add multiply, restoring divide).
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  in_     | in  | tvalid/tready      | tuser: operation
//          |     |                    | tdata: knot_index, knot_term,
//          |     |                    |        knot_rate, query_term
//  out_    | out | tvalid/tready      | tuser: status ; tdata: rate_out
//  cfg_    | in  | wr_en (no wait)    | wr_data: knot_count
//
//  Write request: result valid in the cycle after acceptance.
//  Query: one knot scanned per cycle, then interpolation (rate reads,
//  setup, 32 multiply steps and 33 divide steps on the shared adder);
//  clamped answers take an end knot's rate through S_CLAMP instead.
//  Reset sets knot_count to 20; the knot store is undefined until written.
//  in_tready is low from acceptance until the result is taken; the result
//  holds while out_tready is low.
module piecewise_linear_curve_lookup_top #(
  parameter int MAX_KNOTS = plc_pkg::MAX_KNOTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // config
  input  logic                                cfg_wr_en,
  input  logic [plc_pkg::KNOT_COUNT_W-1:0]    cfg_wr_data,
  // request
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [4:0] knot_index, [36:5] knot_term, [68:37] knot_rate, [100:69] query_term
  input  logic [plc_pkg::IN_TDATA_W-1:0]      in_tdata,
  // [0] operation
  input  logic                                in_tuser,
  // result
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [31:0] rate_out
  output logic [plc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // [2:0] status
  output logic [2:0]                          out_tuser
);

  localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);

  logic [plc_pkg::INDEX_W-1:0] in_knot_index;
  logic [plc_pkg::TERM_W-1:0]  in_knot_term;
  logic [plc_pkg::RATE_W-1:0]  in_knot_rate;
  logic [plc_pkg::TERM_W-1:0]  in_query_term;

  assign in_knot_index = in_tdata[4:0];
  assign in_knot_term  = in_tdata[36:5];
  assign in_knot_rate  = in_tdata[68:37];
  assign in_query_term = in_tdata[100:69];

  logic [31:0] term_mem [MAX_KNOTS];
  logic [31:0] rate_mem [MAX_KNOTS];
  logic [31:0] term_rd_r, rate_rd_r;
  logic [AW-1:0] term_addr, rate_addr, wr_addr;
  logic          mem_we;

  plc_pkg::state_t  state_r, state_nxt;
  plc_pkg::status_t status_r, status_nxt;
  logic [plc_pkg::KNOT_COUNT_W-1:0] knot_count_r;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic [plc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [31:0] prev_r, prev_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [31:0] r0_r, r0_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] hi_r, hi_nxt;
  logic [32:0] lo_r, lo_nxt;
  logic [31:0] rate_out_r, rate_out_nxt;

  logic [33:0] alu_a, alu_b;
  logic        alu_cin;
  logic [34:0] alu_sum;

  logic        in_acc;
  logic        last_knot, first_knot;
  logic [CW-1:0] n_sat;

  assign alu_sum = {1'b0, alu_a} + {1'b0, alu_b} + {34'd0, alu_cin};

  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = (state_r == plc_pkg::S_IDLE);
  assign out_tvalid = (state_r == plc_pkg::S_RESP);
  assign out_tdata  = rate_out_r;
  assign out_tuser  = status_r;

  assign first_knot = (ptr_r == '0);
  assign last_knot  = ((CW'(ptr_r) + CW'(1)) == n_r);
  assign n_sat      = (32'(knot_count_r) > 32'(MAX_KNOTS)) ? CW'(MAX_KNOTS)
                                                           : CW'(knot_count_r);

  assign wr_addr = AW'(in_knot_index);
  assign mem_we  = in_acc && (in_tuser == plc_pkg::OP_WRITE) &&
                   (32'(in_knot_index) < 32'(MAX_KNOTS));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      term_mem[wr_addr] <= in_knot_term;
      rate_mem[wr_addr] <= in_knot_rate;
    end
    term_rd_r <= term_mem[term_addr];
    rate_rd_r <= rate_mem[rate_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= plc_pkg::S_IDLE;
      knot_count_r <= plc_pkg::KNOT_COUNT_RST;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        knot_count_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    status_r   <= status_nxt;
    n_r        <= n_nxt;
    ptr_r      <= ptr_nxt;
    cnt_r      <= cnt_nxt;
    q_r        <= q_nxt;
    prev_r     <= prev_nxt;
    dt_r       <= dt_nxt;
    r0_r       <= r0_nxt;
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    hi_r       <= hi_nxt;
    lo_r       <= lo_nxt;
    rate_out_r <= rate_out_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    n_nxt        = n_r;
    ptr_nxt      = ptr_r;
    cnt_nxt      = cnt_r;
    q_nxt        = q_r;
    prev_nxt     = prev_r;
    dt_nxt       = dt_r;
    r0_nxt       = r0_r;
    mag_nxt      = mag_r;
    neg_nxt      = neg_r;
    hi_nxt       = hi_r;
    lo_nxt       = lo_r;
    rate_out_nxt = rate_out_r;
    term_addr    = AW'(ptr_r + AW'(1));
    rate_addr    = ptr_r;
    alu_a        = '0;
    alu_b        = '0;
    alu_cin      = 1'b0;

    case (state_r)
      plc_pkg::S_IDLE: begin
        term_addr = '0;
        if (in_acc) begin
          ptr_nxt = '0;
          q_nxt   = in_query_term;
          n_nxt   = n_sat;
          if (in_tuser == plc_pkg::OP_WRITE) begin
            rate_out_nxt = '0;
            status_nxt   = plc_pkg::ST_WRITE;
            state_nxt    = plc_pkg::S_RESP;
          end else if (n_sat == '0) begin
            rate_out_nxt = '0;
            status_nxt   = plc_pkg::ST_NONE;
            state_nxt    = plc_pkg::S_RESP;
          end else begin
            state_nxt = plc_pkg::S_SCAN;
          end
        end
      end

      plc_pkg::S_SCAN: begin
        prev_nxt = term_rd_r;
        ptr_nxt  = AW'(ptr_r + AW'(1));
        if (first_knot) begin
          if (term_rd_r >= q_r) begin
            status_nxt = plc_pkg::ST_LOW;
            ptr_nxt    = ptr_r;
            state_nxt  = plc_pkg::S_CLAMP;
          end else if (last_knot) begin
            status_nxt = plc_pkg::ST_HIGH;
            ptr_nxt    = ptr_r;
            state_nxt  = plc_pkg::S_CLAMP;
          end
        end else if (prev_r <= q_r && term_rd_r >= q_r) begin
          rate_addr = AW'(ptr_r - AW'(1));
          prev_nxt  = prev_r;
          ptr_nxt   = ptr_r;
          dt_nxt    = term_rd_r;
          state_nxt = plc_pkg::S_RATE0;
        end else if (last_knot) begin
          ptr_nxt = ptr_r;
          if (term_rd_r <= q_r) begin
            status_nxt = plc_pkg::ST_HIGH;
            state_nxt  = plc_pkg::S_CLAMP;
          end else begin
            rate_out_nxt = '0;
            status_nxt   = plc_pkg::ST_NONE;
            state_nxt    = plc_pkg::S_RESP;
          end
        end
      end

      plc_pkg::S_CLAMP: begin
        rate_out_nxt = rate_rd_r;
        state_nxt    = plc_pkg::S_RESP;
      end

      plc_pkg::S_RATE0: begin
        r0_nxt    = rate_rd_r;
        state_nxt = plc_pkg::S_RATE1;
      end

      plc_pkg::S_RATE1: begin
        mag_nxt   = {rate_rd_r[31], rate_rd_r};
        state_nxt = plc_pkg::S_DT;
      end

      plc_pkg::S_DT: begin
        alu_a     = {2'b00, dt_r};
        alu_b     = ~{2'b00, prev_r};
        alu_cin   = 1'b1;
        dt_nxt    = alu_sum[31:0];
        state_nxt = plc_pkg::S_DQ;
      end

      plc_pkg::S_DQ: begin
        alu_a   = {2'b00, q_r};
        alu_b   = ~{2'b00, prev_r};
        alu_cin = 1'b1;
        if (dt_r == '0) begin
          rate_out_nxt = r0_r;
          status_nxt   = plc_pkg::ST_INTERP;
          state_nxt    = plc_pkg::S_RESP;
        end else begin
          lo_nxt    = {1'b0, alu_sum[31:0]};
          state_nxt = plc_pkg::S_DIFF;
        end
      end

      plc_pkg::S_DIFF: begin
        alu_a     = {mag_r[32], mag_r};
        alu_b     = ~{{2{r0_r[31]}}, r0_r};
        alu_cin   = 1'b1;
        mag_nxt   = alu_sum[32:0];
        neg_nxt   = alu_sum[32];
        hi_nxt    = '0;
        state_nxt = plc_pkg::S_MAG;
      end

      plc_pkg::S_MAG: begin
        alu_a   = '0;
        alu_b   = ~{mag_r[32], mag_r};
        alu_cin = 1'b1;
        if (neg_r) begin
          mag_nxt = alu_sum[32:0];
        end
        cnt_nxt   = '0;
        state_nxt = plc_pkg::S_MUL;
      end

      // shift-add: {hi, lo} becomes mag * dq
      plc_pkg::S_MUL: begin
        alu_a = {1'b0, hi_r};
        alu_b = lo_r[0] ? {1'b0, mag_r} : 34'd0;
        if (cnt_r == plc_pkg::CNT_W'(plc_pkg::MUL_STEPS - 1)) begin
          hi_nxt    = {1'b0, alu_sum[33:2]};
          lo_nxt    = {alu_sum[1], alu_sum[0], lo_r[31:1]};
          cnt_nxt   = '0;
          state_nxt = plc_pkg::S_DIV;
        end else begin
          hi_nxt  = alu_sum[33:1];
          lo_nxt  = {1'b0, alu_sum[0], lo_r[31:1]};
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // restoring divide: hi holds remainder, quotient shifts into lo
      plc_pkg::S_DIV: begin
        alu_a   = {1'b0, hi_r[31:0], lo_r[32]};
        alu_b   = ~{2'b00, dt_r};
        alu_cin = 1'b1;
        if (alu_sum[34]) begin
          hi_nxt = {1'b0, alu_sum[31:0]};
        end else begin
          hi_nxt = {1'b0, hi_r[30:0], lo_r[32]};
        end
        lo_nxt = {lo_r[31:0], alu_sum[34]};
        if (cnt_r == plc_pkg::CNT_W'(plc_pkg::DIV_STEPS - 1)) begin
          state_nxt = plc_pkg::S_FIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      plc_pkg::S_FIN: begin
        alu_a        = {{2{r0_r[31]}}, r0_r};
        alu_b        = neg_r ? ~{1'b0, lo_r} : {1'b0, lo_r};
        alu_cin      = neg_r;
        rate_out_nxt = alu_sum[31:0];
        status_nxt   = plc_pkg::ST_INTERP;
        state_nxt    = plc_pkg::S_RESP;
      end

      plc_pkg::S_RESP: begin
        if (out_tready) begin
          state_nxt = plc_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = plc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/plc_chk.sv]
// ----------------------------------------------------------------------------
// plc_chk : port-level checks for the curve lookup
// Watches the stream ports only; bound to the top level.
// ----------------------------------------------------------------------------
module plc_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic [plc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                            in_tuser,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [plc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [2:0]                      out_tuser
);

  // one request in flight: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while result pending");

  a_write_ack: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == plc_pkg::OP_WRITE) |=>
      (out_tvalid && out_tuser == plc_pkg::ST_WRITE && out_tdata == '0))
    else $error("write not acknowledged next cycle");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == plc_pkg::ST_NONE) |-> (out_tdata == '0))
    else $error("no-segment result with non-zero rate");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == plc_pkg::ST_INTERP || out_tuser == plc_pkg::ST_LOW ||
                    out_tuser == plc_pkg::ST_HIGH || out_tuser == plc_pkg::ST_NONE ||
                    out_tuser == plc_pkg::ST_WRITE))
    else $error("status code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled result changed");

endmodule

bind piecewise_linear_curve_lookup_top plc_chk u_plc_chk (.*);
